>>> rtl/p9b_pkg.sv
package p9b_pkg;
	localparam int MaxWidth = 1024;
	localparam int MaxHeight = 4096;
	localparam int Rad = 4;
	localparam int Span = 2 * Rad + 1;
	localparam int StoreDepth = 2 * Rad * MaxWidth + 2 * Rad + 1;
	localparam int AddrW = $clog2(StoreDepth);
	localparam int ColW = 11;
	localparam int RowW = 13;
	localparam int PosW = 23;
	localparam int SumW = 20;
	localparam int WsW = 10;

	typedef logic [ColW-1:0] col_t;
	typedef logic [RowW-1:0] row_t;
	typedef logic [PosW-1:0] pos_t;

	localparam logic [0:0] RegWidth = 1'b0;
	localparam logic [0:0] RegHeight = 1'b1;
	localparam logic OpPixel = 1'b0;
	localparam logic OpDrain = 1'b1;
endpackage

>>> rtl/pyramid_9x9_blur_filter.sv
// a pixel or drain transfer that produces no result is taken and the block stays ready
// a transfer that produces a result steps through accept, 81 window reads (one per cycle),
// a last accumulate of the registered read data, a restoring divide, then output;
// input is held off until the result is taken
// arst_n clears counters, latched sizes go to 1024x1024; line store is not cleared
module pyramid_9x9_blur_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel_in
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] pixel_out
	output logic        m_tlast,   // end_of_frame
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import p9b_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_LAST, S_DIV, S_OUT} state_t;
	state_t state_q;

	logic [7:0] mem [StoreDepth];
	logic [7:0] rd_q;
	logic [AddrW-1:0] rd_addr;
	logic rd_en, wr_en;
	logic [AddrW-1:0] wr_addr;
	logic [7:0] wr_data;

	col_t cfg_w_q, act_w_q, in_col_q, out_col_q;
	row_t cfg_h_q, act_h_q, in_row_q, out_row_q;

	// raster positions modulo the line store depth
	logic [AddrW-1:0] wr_ptr_q, out_ptr_q;

	// window walk
	logic [3:0] dr_q, dc_q;
	logic acc_v_q;
	logic [3:0] acc_wt_q;
	logic [SumW-1:0] sum_q;
	logic [WsW-1:0] wsum_q;
	logic last_q;
	// divider
	logic [SumW-1:0] quo_q;
	logic [WsW:0] rem_q;
	logic [4:0] div_cnt_q;
	logic [7:0] out_q;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = out_q;
	assign m_tlast = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= col_t'(1024);
			cfg_h_q <= row_t'(1024);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegWidth:  cfg_w_q <= cfg_data[ColW-1:0];
				RegHeight: cfg_h_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// clamped sizes from registers
	col_t cw;
	row_t ch;
	always_comb begin
		cw = cfg_w_q;
		if (cw == '0) cw = col_t'(1);
		else if (cw > col_t'(MaxWidth)) cw = col_t'(MaxWidth);
		ch = cfg_h_q;
		if (ch == '0) ch = row_t'(1);
		else if (ch > row_t'(MaxHeight)) ch = row_t'(MaxHeight);
	end

	// window position for current read
	logic signed [RowW+1:0] rr;
	logic signed [ColW+1:0] cc;
	logic inb;
	logic [3:0] adr, adc, wt;
	always_comb begin
		rr = $signed({2'b00, out_row_q}) + $signed({{(RowW-2){1'b0}}, dr_q}) - 15'sd4;
		cc = $signed({2'b00, out_col_q}) + $signed({{(ColW-2){1'b0}}, dc_q}) - 13'sd4;
		inb = (rr >= 0) && (rr < $signed({2'b00, act_h_q}))
			&& (cc >= 0) && (cc < $signed({2'b00, act_w_q}));
		adr = (dr_q >= 4'd4) ? dr_q - 4'd4 : 4'd4 - dr_q;
		adc = (dc_q >= 4'd4) ? dc_q - 4'd4 : 4'd4 - dc_q;
		wt = 4'(Span) - adr - adc;
	end

	// store address of the window tap: output position plus signed offset, one wrap
	logic signed [4:0] drs, dcs;
	logic signed [16:0] woff, raddr_s;
	always_comb begin
		drs = $signed({1'b0, dr_q}) - 5'sd4;
		dcs = $signed({1'b0, dc_q}) - 5'sd4;
		woff = 17'(drs) * 17'($signed({1'b0, act_w_q})) + 17'(dcs);
		raddr_s = $signed({3'b000, out_ptr_q}) + woff;
		if (raddr_s < 0) raddr_s = raddr_s + 17'(StoreDepth);
		else if (raddr_s >= 17'(StoreDepth)) raddr_s = raddr_s - 17'(StoreDepth);
	end

	// input handling
	logic acc_in, is_drain, idle_cnt, do_emit;
	col_t w_use;
	row_t h_use;
	pos_t n_in, n_out;
	col_t nxt_col;
	row_t nxt_row;
	always_comb begin
		acc_in = s_tvalid && s_tready;
		idle_cnt = (in_row_q == '0) && (in_col_q == '0) && (out_row_q == '0)
			&& (out_col_q == '0);
		is_drain = (s_tuser == OpDrain);
		w_use = (!is_drain && idle_cnt) ? cw : act_w_q;
		h_use = (!is_drain && idle_cnt) ? ch : act_h_q;
		n_in = pos_t'(in_row_q) * pos_t'(w_use) + pos_t'(in_col_q) + pos_t'(1);
		n_out = pos_t'(out_row_q) * pos_t'(w_use) + pos_t'(out_col_q);
		nxt_col = in_col_q + col_t'(1);
		nxt_row = in_row_q;
		if (nxt_col >= w_use) begin
			nxt_col = '0;
			nxt_row = in_row_q + row_t'(1);
		end
		if (is_drain || in_row_q >= h_use) do_emit = (in_row_q >= h_use);
		else do_emit = (n_in - n_out) > (pos_t'(w_use) * pos_t'(Rad) + pos_t'(Rad));
		wr_en = acc_in && !is_drain && (in_row_q < h_use);
		wr_addr = wr_ptr_q;
		wr_data = s_tdata;
		rd_en = (state_q == S_READ);
		rd_addr = raddr_s[AddrW-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	logic [WsW:0] trial;
	always_comb trial = {rem_q[WsW-1:0], quo_q[SumW-1]} - {1'b0, wsum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_w_q <= col_t'(1024);
			act_h_q <= row_t'(1024);
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			wr_ptr_q <= '0;
			out_ptr_q <= '0;
			dr_q <= '0;
			dc_q <= '0;
			acc_v_q <= 1'b0;
			last_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						act_w_q <= w_use;
						act_h_q <= h_use;
						if (wr_en) begin
							in_col_q <= nxt_col;
							in_row_q <= nxt_row;
							wr_ptr_q <= (wr_ptr_q == AddrW'(StoreDepth - 1)) ? '0
								: wr_ptr_q + AddrW'(1);
						end
						if (do_emit) begin
							state_q <= S_READ;
							dr_q <= '0;
							dc_q <= '0;
							sum_q <= '0;
							wsum_q <= '0;
							acc_v_q <= 1'b0;
						end
					end
				end
				S_READ: begin
					// accumulate previous read while issuing next
					if (acc_v_q) begin
						sum_q <= sum_q + SumW'(acc_wt_q) * SumW'(rd_q);
						wsum_q <= wsum_q + WsW'(acc_wt_q);
					end
					acc_v_q <= inb;
					acc_wt_q <= wt;
					if (dc_q == 4'd8) begin
						dc_q <= '0;
						if (dr_q == 4'd8) state_q <= S_LAST;
						else dr_q <= dr_q + 4'd1;
					end else begin
						dc_q <= dc_q + 4'd1;
					end
				end
				S_LAST: begin
					if (acc_v_q) begin
						quo_q <= sum_q + SumW'(acc_wt_q) * SumW'(rd_q);
						wsum_q <= wsum_q + WsW'(acc_wt_q);
					end else begin
						quo_q <= sum_q;
					end
					rem_q <= '0;
					div_cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (!trial[WsW]) begin
						rem_q <= trial;
						quo_q <= {quo_q[SumW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[WsW-1:0], quo_q[SumW-1]};
						quo_q <= {quo_q[SumW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(SumW - 1)) begin
						state_q <= S_OUT;
						last_q <= (out_row_q == act_h_q - row_t'(1))
							&& (out_col_q == act_w_q - col_t'(1));
					end
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
						if (last_q) begin
							in_col_q <= '0;
							in_row_q <= '0;
							out_col_q <= '0;
							out_row_q <= '0;
							wr_ptr_q <= '0;
							out_ptr_q <= '0;
						end else begin
							out_ptr_q <= (out_ptr_q == AddrW'(StoreDepth - 1)) ? '0
								: out_ptr_q + AddrW'(1);
							if (out_col_q + col_t'(1) >= act_w_q) begin
								out_col_q <= '0;
								out_row_q <= out_row_q + row_t'(1);
							end else begin
								out_col_q <= out_col_q + col_t'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// quotient low byte captured as divide completes
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_cnt_q == 5'(SumW - 1))
			out_q <= (wsum_q == '0) ? 8'd0 : {quo_q[6:0], ~trial[WsW]};
	end
endmodule

>>> verif/tb_pyramid_9x9_blur_filter.sv
`timescale 1ns / 100ps

module tb_pyramid_9x9_blur_filter;
	import p9b_pkg::*;

	// one filtered pixel as it leaves the block
	typedef struct {
		logic [7:0] pix;
		logic       eof;
	} blur_px_t;

	// reference filter plus the queue of filtered pixels still owed by the block
	class blur_scoreboard;
		byte unsigned store [StoreDepth];
		int unsigned  reg_w, reg_h, act_w, act_h;
		int unsigned  in_col, in_row, out_col, out_row;
		blur_px_t     expected [$];
		int           errors;

		function new();
			foreach (store[i]) store[i] = 0;
			reg_w = MaxWidth;
			reg_h = 1024;
			act_w = clamp_w(reg_w);
			act_h = clamp_h(reg_h);
			in_col = 0; in_row = 0; out_col = 0; out_row = 0;
			errors = 0;
		endfunction

		function void report(string msg);
			errors++;
			$display("mismatch @%0t: %s", $time, msg);
		endfunction

		function int unsigned clamp_w(int unsigned w);
			if (w == 0) return 1;
			if (w > MaxWidth) return MaxWidth;
			return w;
		endfunction

		function int unsigned clamp_h(int unsigned h);
			if (h == 0) return 1;
			if (h > MaxHeight) return MaxHeight;
			return h;
		endfunction

		function void write_reg(logic [0:0] idx, logic [12:0] val);
			if (idx == RegWidth) reg_w = val[10:0];
			else reg_h = val;
		endfunction

		// pyramid weighted mean over the in-image part of the 9x9 window
		function logic [7:0] blur_at(int r, int c);
			int unsigned acc, wacc, wt, p;
			int rr, cc;
			acc = 0;
			wacc = 0;
			for (int dr = -Rad; dr <= Rad; dr++) begin
				rr = r + dr;
				if (rr < 0 || rr >= int'(act_h)) continue;
				for (int dc = -Rad; dc <= Rad; dc++) begin
					cc = c + dc;
					if (cc < 0 || cc >= int'(act_w)) continue;
					wt = Span - (dr < 0 ? -dr : dr) - (dc < 0 ? -dc : dc);
					p = (rr * act_w + cc) % StoreDepth;
					acc += wt * store[p];
					wacc += wt;
				end
			end
			if (wacc == 0) return 8'd0;
			return 8'(acc / wacc);
		endfunction

		function void emit();
			blur_px_t e;
			e.pix = blur_at(out_row, out_col);
			e.eof = (out_row == act_h - 1) && (out_col == act_w - 1);
			expected.push_back(e);
			if (e.eof) begin
				in_col = 0; in_row = 0; out_col = 0; out_row = 0;
			end else begin
				out_col++;
				if (out_col >= act_w) begin
					out_col = 0;
					out_row++;
				end
			end
		endfunction

		function bit at_rest();
			return in_row == 0 && in_col == 0 && out_row == 0 && out_col == 0;
		endfunction

		function bit input_done();
			return in_row >= act_h;
		endfunction

		function void note_input(logic op, logic [7:0] pix);
			int unsigned n_in, n_out, lag;
			// sizes latch on the first pixel of a frame
			if (op == OpPixel && at_rest()) begin
				act_w = clamp_w(reg_w);
				act_h = clamp_h(reg_h);
			end
			if (op == OpDrain || in_row >= act_h) begin
				// pixel after a complete frame acts as a drain
				if (in_row >= act_h) emit();
				return;
			end
			n_in = in_row * act_w + in_col;
			store[n_in % StoreDepth] = pix;
			in_col++;
			if (in_col >= act_w) begin
				in_col = 0;
				in_row++;
			end
			n_out = out_row * act_w + out_col;
			lag = Rad * act_w + Rad;
			if (n_in + 1 - n_out > lag) emit();
		endfunction

		function void check_result(logic [7:0] pix, logic eof);
			blur_px_t e;
			if (expected.size() == 0) begin
				report($sformatf("unexpected pixel %0d last %0b", pix, eof));
				return;
			end
			e = expected.pop_front();
			if (pix !== e.pix)
				report($sformatf("pixel_out %0d, want %0d", pix, e.pix));
			if (eof !== e.eof)
				report($sformatf("end_of_frame %0b, want %0b", eof, e.eof));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] pixel_in
	logic        s_tuser;   // [0] op
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] pixel_out
	logic        m_tlast;   // end_of_frame
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [12:0] cfg_data;

	blur_scoreboard sb;

	// idle percentages of the current phase, in cycles per hundred
	int send_gap_pct;
	int recv_stall_pct;
	// long receiver hold-off: main bumps the request count, receiver counts the stretch
	int hold_req;
	int hold_seen;
	int hold_left;
	int pix_mode;
	int pix_count;
	int random_pixels;

	pyramid_9x9_blur_filter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit, well above the slowest correct run
	initial begin
		#40ms;
		$display("** pyramid_9x9_blur_filter: FAILED **");
		$finish;
	end

	// one register write transfer; valid drops for a cycle before the next write
	task automatic write_reg(logic [0:0] idx, logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one input transfer with random sender gaps in front; valid stays up if no gap
	task automatic send(logic op, logic [7:0] pix);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, pix);
	endtask

	function automatic logic [7:0] next_pixel();
		pix_count++;
		case (pix_mode)
			1: return 8'hff;
			2: return 8'h00;
			3: return pix_count[0] ? 8'hff : 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	// wait until every owed pixel has come and the block has settled
	task automatic settle();
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// one whole frame: sizes, pixels with drain noise, then drains until the last pixel
	task automatic run_frame(int idx, logic [12:0] w, logic [12:0] h, int mode, int drain_pct);
		case (idx % 4)
			0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
			2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
			default: begin send_gap_pct = 25; recv_stall_pct = 25; end
		endcase
		settle();
		write_reg(RegWidth, w);
		write_reg(RegHeight, h);
		pix_mode = mode;
		// stray drain while idle, causes nothing
		if ($urandom_range(3) == 0) send(OpDrain, 8'($urandom));
		send(OpPixel, next_pixel());
		while (!sb.input_done()) begin
			if ($urandom_range(99) < drain_pct) send(OpDrain, 8'($urandom));
			else send(OpPixel, next_pixel());
		end
		while (!sb.at_rest()) begin
			if ($urandom_range(3) == 0) send(OpPixel, 8'($urandom));
			else send(OpDrain, 8'($urandom));
		end
		s_tvalid <= 1'b0;
	endtask

	// receiver: check every output transfer, then decide ready for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int fidx;
		int w, h;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OpPixel;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = RegWidth;
		cfg_data = '0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		pix_count = 0;
		random_pixels = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames: smallest image, zero sizes, extreme pixel values
		run_frame(0, 13'd1, 13'd1, 1, 0);
		run_frame(1, 13'd0, 13'd0, 2, 0);
		run_frame(2, 13'd3, 13'd2, 3, 30);
		run_frame(3, 13'd2, 13'd9, 1, 10);
		run_frame(4, 13'd9, 13'd5, 0, 10);

		fidx = 5;
		while (random_pixels < 1000) begin
			if ($urandom_range(9) == 0) begin
				w = $urandom_range(17, 64);
				h = $urandom_range(1, 4);
			end else begin
				w = $urandom_range(1, 16);
				h = $urandom_range(1, 12);
			end
			// long receiver hold-off while the sender keeps offering pixels
			if (fidx == 6) begin
				w = 16;
				h = 12;
				hold_req = hold_req + 1;
			end
			random_pixels += w * h;
			run_frame(fidx, 13'(w), 13'(h), ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0,
				$urandom_range(0, 20));
			fidx++;
		end

		settle();
		if (sb.errors == 0) begin
			$display("** pyramid_9x9_blur_filter: PASSED **");
		end else begin
			$display("** pyramid_9x9_blur_filter: FAILED **");
		end
		$finish;
	end
endmodule
